// ===== rtl/contiguous_frame_allocator_assert.svh =====
// Assertion macros shared by the frame allocator RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfa_pkg.sv =====
// Package for the contiguous frame allocator: field widths, request kinds,
// status codes and the scan step helper. No dependencies.
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int KIND_W        = 2;
  localparam int CNT_W         = 11;
  localparam int FRAME_W       = 10;
  localparam int STATUS_W      = 2;
  localparam int SCAN_STEP_MAX = 8;

  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [FRAME_W-1:0] frame_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE_REC = 2'd1,
    KIND_FREE_CNT = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_ZERO   = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // Number of bitmap bits examined per cycle: the largest of SCAN_STEP_MAX, 4, 2 and 1 that divides the word.
  function automatic int scan_step(input int word_bits);
    int step;
    step = 1;
    if (word_bits % SCAN_STEP_MAX == 0) begin
      step = SCAN_STEP_MAX;
    end else if (word_bits % 4 == 0) begin
      step = 4;
    end else if (word_bits % 2 == 0) begin
      step = 2;
    end
    return step;
  endfunction

endpackage

// ===== rtl/cfa_req_if.sv =====
// Request channel of the frame allocator: valid/ready plus the request fields.
// Depends on cfa_pkg for the field widths.
`timescale 1ns / 1ps

interface cfa_req_if import cfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  count_t              page_count;
  frame_t              frame_index;

  modport source (output valid, output kind, output page_count, output frame_index,
                  input ready);
  modport sink   (input valid, input kind, input page_count, input frame_index,
                  output ready);
endinterface

// ===== rtl/cfa_rsp_if.sv =====
// Response channel of the frame allocator: valid/ready plus the result fields.
// Depends on cfa_pkg for the field widths.
`timescale 1ns / 1ps

interface cfa_rsp_if import cfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  frame_t              start_frame;

  modport source (output valid, output status, output start_frame, input ready);
  modport sink   (input valid, input status, input start_frame, output ready);
endinterface

// ===== rtl/cfa_run_scan.sv =====
// One step of the first-fit search: walks STEP bitmap bits and extends or restarts
// the current run of free frames. Depends on cfa_pkg.
`timescale 1ns / 1ps

module cfa_run_scan import cfa_pkg::*; #(
  parameter int STEP = 8,
  parameter int PW   = 10
) (
  input  logic [STEP-1:0] bits_i,
  input  logic [PW-1:0]   pos_i,
  input  count_t          count_i,
  input  count_t          run_i,
  input  logic [PW-1:0]   first_i,
  output count_t          run_o,
  output logic [PW-1:0]   first_o,
  output logic            start_o,
  output logic            hit_o
);

  always_comb begin
    count_t        run_v;
    logic [PW-1:0] first_v;
    logic          start_v;
    logic          hit_v;
    run_v   = run_i;
    first_v = first_i;
    start_v = 1'b0;
    hit_v   = 1'b0;
    for (int i = 0; i < STEP; i++) begin
      if (!hit_v) begin
        if (bits_i[i]) begin
          if (run_v == '0) begin
            first_v = pos_i + PW'(i);
            start_v = 1'b1;
          end
          run_v = run_v + count_t'(1);
          if (run_v == count_i) begin
            hit_v = 1'b1;
          end
        end else begin
          run_v = '0;
        end
      end
    end
    run_o   = run_v;
    first_o = first_v;
    start_o = start_v;
    hit_o   = hit_v;
  end

endmodule

// ===== rtl/contiguous_frame_allocator.sv =====
// Contiguous frame allocator top level: FSM, free bitmap and run length memories.
// Depends on cfa_pkg, cfa_req_if, cfa_rsp_if, cfa_run_scan and the assertion header.
`timescale 1ns / 1ps
`include "contiguous_frame_allocator_assert.svh"

// The allocator keeps one bit per frame in a bitmap memory of MAP_WORD_BITS-bit
// words (a set bit means the frame is free) and a run length memory with one
// entry per frame. It handles one request at a time. After reset a clearing
// pass zeroes both memories; no request is taken during it. An allocate with a
// nonzero count reads the bitmap word by word, examines up to eight bits per
// cycle and stops early once a run fits. The found run is then marked used
// with one read and one write per bitmap word it touches. A free first reads
// the recorded length, steps word by word to the word that holds its first
// frame and marks the run free with one read and one write per word, unless
// the frame is out of range or the length is zero. Each result then goes into
// the output register, which holds it until the sink takes it.
module contiguous_frame_allocator import cfa_pkg::*; #(
  parameter int FRAMES        = 1024,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfa_req_if.sink   req_i,
  cfa_rsp_if.source rsp_o
);

  localparam int MAP_WORDS = (FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FW        = $clog2(FRAMES);
  localparam int PW        = $clog2(MAP_WORDS * MAP_WORD_BITS);
  localparam int STEP      = scan_step(MAP_WORD_BITS);
  localparam int NCHUNK    = MAP_WORD_BITS / STEP;
  localparam int CHW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b0_0000_0001,
    S_IDLE    = 9'b0_0000_0010,
    S_LOAD    = 9'b0_0000_0100,
    S_SCAN    = 9'b0_0000_1000,
    S_FREE    = 9'b0_0001_0000,
    S_SEEK    = 9'b0_0010_0000,
    S_MARK_RD = 9'b0_0100_0000,
    S_MARK_WR = 9'b0_1000_0000,
    S_RESP    = 9'b1_0000_0000
  } state_e;

  // Control registers (reset).
  state_e  state_q, state_d;
  logic [FW-1:0] clr_q, clr_d;
  logic    out_valid_q, out_valid_d;

  // Datapath registers (no reset needed).
  kind_e   kind_q, kind_d;
  count_t  cnt_q, cnt_d;
  frame_t  frame_q, frame_d;
  status_e status_q, status_d;
  frame_t  start_q, start_d;
  logic [MA-1:0] word_q, word_d;
  logic [PW-1:0] base_q, base_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CHW-1:0] chunk_q, chunk_d;
  logic [MAP_WORD_BITS-1:0] scan_word_q, scan_word_d;
  count_t  run_q, run_d;
  logic [PW-1:0] first_q, first_d;
  logic [MA-1:0] fword_q, fword_d;
  logic [PW-1:0] fbase_q, fbase_d;
  logic [PW-1:0] s_q, s_d;
  logic [PW-1:0] e_q, e_d;
  logic    mark_free_q, mark_free_d;
  status_e out_status_q, out_status_d;
  frame_t  out_start_q, out_start_d;

  // Bitmap memory.
  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] map_rdata_q;
  logic                     map_we, map_re;
  logic [MA-1:0]            map_waddr, map_raddr;
  logic [MAP_WORD_BITS-1:0] map_wdata;

  // Run length memory.
  count_t        rl_mem [FRAMES];
  count_t        rl_rdata_q;
  logic          rl_we, rl_re;
  logic [FW-1:0] rl_waddr, rl_raddr;
  count_t        rl_wdata;

  // Scan step outputs.
  count_t        scan_run;
  logic [PW-1:0] scan_first;
  logic          scan_start;
  logic          scan_hit;

  logic                     accept;
  logic                     last_chunk;
  logic                     last_word;
  logic [MA+1:0]            next2;
  logic                     next2_ok;
  count_t                   free_len;
  logic [31:0]              free_end;
  logic [31:0]              free_last;
  logic                     frame_oor;
  logic [MAP_WORD_BITS-1:0] mark_mask;
  logic [MAP_WORD_BITS-1:0] map_new;
  logic [PW:0]              base_next;
  logic                     seek_done;
  logic                     word_has_end;

  assign req_i.ready       = (state_q == S_IDLE);
  assign accept            = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.start_frame = out_start_q;

  cfa_run_scan #(
    .STEP (STEP),
    .PW   (PW)
  ) u_run_scan (
    .bits_i  (scan_word_q[STEP-1:0]),
    .pos_i   (pos_q),
    .count_i (cnt_q),
    .run_i   (run_q),
    .first_i (first_q),
    .run_o   (scan_run),
    .first_o (scan_first),
    .start_o (scan_start),
    .hit_o   (scan_hit)
  );

  assign last_chunk = (chunk_q == CHW'(NCHUNK - 1));
  assign last_word  = (word_q == MA'(MAP_WORDS - 1));
  assign next2      = (MA+2)'(word_q) + (MA+2)'(2);
  assign next2_ok   = 32'(next2) < 32'(MAP_WORDS);

  // A free takes its length from the request or from the recorded length,
  // and stops at the last frame.
  assign free_len  = (kind_q == KIND_FREE_REC) ? rl_rdata_q : cnt_q;
  assign free_end  = 32'(frame_q) + 32'(free_len);
  assign free_last = ((free_end > 32'(FRAMES)) ? 32'(FRAMES) : free_end) - 32'd1;
  assign frame_oor = 32'(frame_q) >= 32'(FRAMES);

  // Bits of the current word that fall inside the run [s_q, e_q].
  always_comb begin
    logic [PW:0] p;
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      p = (PW+1)'(base_q) + (PW+1)'(j);
      mark_mask[j] = (p >= (PW+1)'(s_q)) && (p <= (PW+1)'(e_q));
    end
  end

  assign map_new      = mark_free_q ? (map_rdata_q | mark_mask) : (map_rdata_q & ~mark_mask);
  assign base_next    = (PW+1)'(base_q) + (PW+1)'(MAP_WORD_BITS);
  assign seek_done    = base_next > (PW+1)'(s_q);
  assign word_has_end = base_next > (PW+1)'(e_q);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    frame_d      = frame_q;
    status_d     = status_q;
    start_d      = start_q;
    word_d       = word_q;
    base_d       = base_q;
    pos_d        = pos_q;
    chunk_d      = chunk_q;
    scan_word_d  = scan_word_q;
    run_d        = run_q;
    first_d      = first_q;
    fword_d      = fword_q;
    fbase_d      = fbase_q;
    s_d          = s_q;
    e_d          = e_q;
    mark_free_d  = mark_free_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;

    map_we    = 1'b0;
    map_waddr = word_q;
    map_wdata = map_new;
    map_re    = 1'b0;
    map_raddr = word_q;
    rl_we     = 1'b0;
    rl_waddr  = clr_q;
    rl_wdata  = '0;
    rl_re     = 1'b0;
    rl_raddr  = FW'(req_i.frame_index);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        rl_we     = 1'b1;
        rl_waddr  = clr_q;
        rl_wdata  = '0;
        map_we    = 32'(clr_q) < 32'(MAP_WORDS);
        map_waddr = MA'(clr_q);
        map_wdata = '0;
        if (clr_q == FW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + FW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_e'(req_i.kind);
          cnt_d    = req_i.page_count;
          frame_d  = req_i.frame_index;
          status_d = ST_DONE;
          case (kind_e'(req_i.kind))
            KIND_ALLOC: begin
              start_d = '0;
              if (req_i.page_count == '0) begin
                status_d = ST_ZERO;
                state_d  = S_RESP;
              end else begin
                map_re    = 1'b1;
                map_raddr = '0;
                state_d   = S_LOAD;
              end
            end
            KIND_FREE_REC, KIND_FREE_CNT: begin
              start_d = req_i.frame_index;
              rl_re   = 1'b1;
              state_d = S_FREE;
            end
            default: begin
              // The unused kind is answered as done and changes nothing.
              start_d = req_i.frame_index;
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_LOAD: begin
        // Word 0 is in the read register; fetch word 1 ahead of time.
        scan_word_d = map_rdata_q;
        word_d      = '0;
        base_d      = '0;
        pos_d       = '0;
        chunk_d     = '0;
        run_d       = '0;
        if (MAP_WORDS > 1) begin
          map_re    = 1'b1;
          map_raddr = MA'(1);
        end
        state_d = S_SCAN;
      end

      S_SCAN: begin
        run_d   = scan_run;
        first_d = scan_first;
        if (scan_start) begin
          fword_d = word_q;
          fbase_d = base_q;
        end
        if (scan_hit) begin
          rl_we       = 1'b1;
          rl_waddr    = FW'(scan_first);
          rl_wdata    = cnt_q;
          start_d     = FRAME_W'(scan_first);
          s_d         = scan_first;
          e_d         = PW'(32'(scan_first) + 32'(cnt_q) - 32'd1);
          mark_free_d = 1'b0;
          word_d      = scan_start ? word_q : fword_q;
          base_d      = scan_start ? base_q : fbase_q;
          state_d     = S_MARK_RD;
        end else if (last_chunk) begin
          if (last_word) begin
            status_d = ST_NO_FIT;
            start_d  = '0;
            state_d  = S_RESP;
          end else begin
            // Move on to the prefetched word and fetch the one after it.
            scan_word_d = map_rdata_q;
            word_d      = word_q + MA'(1);
            base_d      = base_q + PW'(MAP_WORD_BITS);
            pos_d       = pos_q + PW'(STEP);
            chunk_d     = '0;
            if (next2_ok) begin
              map_re    = 1'b1;
              map_raddr = MA'(next2);
            end
          end
        end else begin
          scan_word_d = scan_word_q >> STEP;
          pos_d       = pos_q + PW'(STEP);
          chunk_d     = chunk_q + CHW'(1);
        end
      end

      S_FREE: begin
        if (frame_oor) begin
          status_d = ST_RANGE;
          state_d  = S_RESP;
        end else if (free_len == '0) begin
          status_d = ST_ZERO;
          state_d  = S_RESP;
        end else begin
          s_d         = PW'(frame_q);
          e_d         = PW'(free_last);
          mark_free_d = 1'b1;
          word_d      = '0;
          base_d      = '0;
          state_d     = S_SEEK;
        end
      end

      S_SEEK: begin
        if (seek_done) begin
          state_d = S_MARK_RD;
        end else begin
          word_d = word_q + MA'(1);
          base_d = base_q + PW'(MAP_WORD_BITS);
        end
      end

      S_MARK_RD: begin
        map_re    = 1'b1;
        map_raddr = word_q;
        state_d   = S_MARK_WR;
      end

      S_MARK_WR: begin
        map_we    = 1'b1;
        map_waddr = word_q;
        map_wdata = map_new;
        if (word_has_end) begin
          state_d = S_RESP;
        end else begin
          word_d  = word_q + MA'(1);
          base_d  = base_q + PW'(MAP_WORD_BITS);
          state_d = S_MARK_RD;
        end
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_start_d  = start_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    cnt_q        <= cnt_d;
    frame_q      <= frame_d;
    status_q     <= status_d;
    start_q      <= start_d;
    word_q       <= word_d;
    base_q       <= base_d;
    pos_q        <= pos_d;
    chunk_q      <= chunk_d;
    scan_word_q  <= scan_word_d;
    run_q        <= run_d;
    first_q      <= first_d;
    fword_q      <= fword_d;
    fbase_q      <= fbase_d;
    s_q          <= s_d;
    e_q          <= e_d;
    mark_free_q  <= mark_free_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    if (rl_re) begin
      rl_rdata_q <= rl_mem[rl_raddr];
    end
  end

  `CFA_ASSERT_SAME(a_map_rw_apart, map_we && map_re, map_waddr != map_raddr, "bitmap read and write hit the same word")
  `CFA_ASSERT_SAME(a_scan_run_short, state_q == S_SCAN, run_q < cnt_q, "scan kept going after the run was long enough")
  `CFA_ASSERT_SAME(a_mark_range_ok, state_q == S_MARK_WR, (s_q <= e_q) && (32'(e_q) < 32'(FRAMES)), "marked run is empty or runs past the last frame")
  `CFA_ASSERT_NEXT(a_accept_leaves_idle, req_i.valid && req_i.ready, state_q != S_IDLE, "accepted item was dropped in idle")

endmodule

// ===== test/frame_alloc_checker.sv =====
// Checker for the contiguous frame allocator: watches both channels, keeps its own
// copy of the free bitmap and run lengths, and compares every response in order.
// Depends on cfa_pkg, cfa_req_if and cfa_rsp_if.
`timescale 1ns / 1ps

module frame_alloc_checker import cfa_pkg::*; #(
  parameter int FRAMES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfa_req_if   req_i,
  cfa_rsp_if   rsp_i,
  output int   errors_o,
  output int   due_o,
  output int   checked_o
);

  typedef struct packed {
    status_e status;
    frame_t  start_frame;
  } answer_t;

  bit [FRAMES-1:0] free_map;
  count_t          run_len [FRAMES];
  answer_t         answers_due [$];
  int              err_cnt = 0;
  int              rsp_cnt = 0;

  // Applies one request to the bitmap and the length store and returns its answer.
  function automatic answer_t serve_request(input kind_e op, input count_t cnt,
                                            input frame_t frm);
    answer_t ans;
    int      run;
    int      first;
    int      stop;
    int      n;
    int      i;
    ans.status      = ST_DONE;
    ans.start_frame = '0;
    run   = 0;
    first = 0;
    case (op)
      KIND_ALLOC: begin
        if (cnt == '0) begin
          ans.status = ST_ZERO;
        end else begin
          for (i = 0; i < FRAMES && run < int'(cnt); i++) begin
            if (free_map[i]) begin
              if (run == 0) first = i;
              run++;
            end else begin
              run = 0;
            end
          end
          if (run >= int'(cnt)) begin
            for (i = first; i < first + int'(cnt); i++) free_map[i] = 1'b0;
            run_len[first]  = cnt;
            ans.start_frame = frame_t'(first);
          end else begin
            ans.status = ST_NO_FIT;
          end
        end
      end
      KIND_FREE_REC, KIND_FREE_CNT: begin
        ans.start_frame = frm;
        if (int'(frm) >= FRAMES) begin
          ans.status = ST_RANGE;
        end else begin
          n = (op == KIND_FREE_REC) ? int'(run_len[frm]) : int'(cnt);
          if (n == 0) begin
            ans.status = ST_ZERO;
          end else begin
            stop = int'(frm) + n;
            if (stop > FRAMES) stop = FRAMES;
            for (i = int'(frm); i < stop; i++) free_map[i] = 1'b1;
          end
        end
      end
      default: begin
        ans.start_frame = frm;
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      free_map = '0;
      for (int f = 0; f < FRAMES; f++) run_len[f] = '0;
      answers_due.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        answers_due.push_back(serve_request(kind_e'(req_i.kind), req_i.page_count,
                                            req_i.frame_index));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_cnt++;
        if (answers_due.size() == 0) begin
          $error("response with no request outstanding: status %0d start_frame %0d",
                 rsp_i.status, rsp_i.start_frame);
          err_cnt++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_i.status);
            err_cnt++;
          end
          if (rsp_i.start_frame !== want.start_frame) begin
            $error("start_frame mismatch: expected %0d, got %0d",
                   want.start_frame, rsp_i.start_frame);
            err_cnt++;
          end
        end
      end
    end
    errors_o  <= err_cnt;
    due_o     <= answers_due.size();
    checked_o <= rsp_cnt;
  end

endmodule

// ===== test/tb.sv =====
// Top of the frame allocator testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on cfa_pkg, both channel interfaces,
// frame_alloc_checker and the allocator RTL.
`timescale 1ns / 1ps

module tb import cfa_pkg::*;;

  localparam int FRAMES      = 1024;
  localparam int RAND_ITEMS  = 1900;
  localparam int CYCLE_LIMIT = 2000000;
  // Longest item is a full scan plus marking every word.
  localparam int DRAIN_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfa_req_if req ();
  cfa_rsp_if rsp ();

  int errors;
  int due;
  int checked;

  // Idle percentages for the two sides; the stimulus changes them per phase.
  int send_idle = 38;
  int recv_idle = 53;

  // The kind of each accepted request, in order, so that the start frame of a
  // granted allocation can be kept for a later free by recorded length.
  kind_e kinds_in_flight [$];
  int    live_starts [$];
  int    cycles   = 0;
  int    granted  = 0;
  int    n_alloc  = 0;
  int    n_frec   = 0;
  int    n_fcnt   = 0;
  int    n_rsvd   = 0;

  contiguous_frame_allocator #(
    .FRAMES       (FRAMES),
    .MAP_WORD_BITS(32)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  frame_alloc_checker #(
    .FRAMES(FRAMES)
  ) chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rsp_i    (rsp),
    .errors_o (errors),
    .due_o    (due),
    .checked_o(checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog. The slowest legal run is well below this limit, so reaching it
  // means the block has stopped answering.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Response side: ready is redrawn at every falling edge.
  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Track granted allocations so that frees by recorded length mostly hit
  // real run starts instead of entries that still hold zero.
  always @(posedge clk_i) begin
    kind_e k;
    if (rst_ni && rsp.valid && rsp.ready && kinds_in_flight.size() != 0) begin
      k = kinds_in_flight.pop_front();
      if (k == KIND_ALLOC && rsp.status == ST_DONE) begin
        live_starts.push_back(int'(rsp.start_frame));
        granted++;
      end
    end
  end

  // Offers one item, with random idle cycles first, and returns at the falling
  // edge after it was accepted. Valid is left high between back-to-back items;
  // the drain lowers it, as does the next call when it idles first.
  task automatic push_request(input kind_e k, input int cnt, input int frm);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.kind        <= k;
    req.page_count  <= count_t'(cnt);
    req.frame_index <= frame_t'(frm);
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    kinds_in_flight.push_back(k);
    case (k)
      KIND_ALLOC:    n_alloc++;
      KIND_FREE_REC: n_frec++;
      KIND_FREE_CNT: n_fcnt++;
      default:       n_rsvd++;
    endcase
    @(negedge clk_i);
  endtask

  // Holds the request side quiet until every response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (due != 0) @(negedge clk_i);
  endtask

  // One random item. Allocations use mostly small counts, frees by record
  // mostly target a live run start, and frees by count keep the pool from
  // draining. Returns 0 for the reserved kind, which the block ignores.
  task automatic random_item(output bit counted);
    int r;
    int p;
    int cnt;
    int frm;
    int idx;
    r = $urandom_range(99);
    p = $urandom_range(99);
    counted = 1'b1;
    if (r < 40) begin
      if (p < 80)      cnt = $urandom_range(32, 1);
      else if (p < 92) cnt = $urandom_range(300, 33);
      else if (p < 96) cnt = $urandom_range(1024, 301);
      else if (p < 98) cnt = 0;
      else             cnt = $urandom_range(2047, 1025);
      push_request(KIND_ALLOC, cnt, $urandom_range(1023));
    end else if (r < 70) begin
      if (live_starts.size() != 0 && p < 85) begin
        idx = $urandom_range(live_starts.size() - 1);
        frm = live_starts[idx];
        live_starts.delete(idx);
      end else begin
        frm = $urandom_range(1023);
      end
      push_request(KIND_FREE_REC, $urandom_range(2047), frm);
    end else if (r < 95) begin
      if (p < 2) begin
        // Return the whole pool now and then.
        frm = 0;
        cnt = FRAMES;
      end else begin
        frm = $urandom_range(1023);
        if (p < 90)      cnt = $urandom_range(48, 1);
        else if (p < 97) cnt = $urandom_range(2047, 49);
        else             cnt = 0;
      end
      push_request(KIND_FREE_CNT, cnt, frm);
    end else begin
      push_request(KIND_RSVD, $urandom_range(2047), $urandom_range(1023));
      counted = 1'b0;
    end
  endtask

  initial begin
    int  done_items;
    bit  counted;
    req.valid       = 1'b0;
    req.kind        = KIND_ALLOC;
    req.page_count  = '0;
    req.frame_index = '0;
    rst_ni          = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. After reset every frame is in use, so the first requests
    // fail or are no-ops; then the whole pool is freed and exercised at both
    // extremes, with a small first-fit scenario that leaves a hole too short
    // for the next request.
    push_request(KIND_ALLOC, 1, 0);           // nothing free
    push_request(KIND_ALLOC, 0, 1023);        // zero count
    push_request(KIND_FREE_REC, 0, 5);        // recorded length is still zero
    push_request(KIND_FREE_CNT, 0, 0);        // explicit zero count
    push_request(KIND_RSVD, 2047, 1023);      // reserved kind is ignored
    push_request(KIND_FREE_CNT, FRAMES, 0);   // whole pool free
    push_request(KIND_ALLOC, FRAMES, 0);      // takes every frame
    push_request(KIND_ALLOC, 1, 0);           // nothing left
    push_request(KIND_FREE_REC, 0, 0);        // recorded 1024 frees all
    push_request(KIND_ALLOC, 2047, 0);        // larger than the pool
    push_request(KIND_ALLOC, FRAMES + 1, 0);
    push_request(KIND_FREE_CNT, 2047, 1020);  // clipped at the last frame
    push_request(KIND_FREE_CNT, 1, 1023);     // frame already free
    push_request(KIND_ALLOC, 3, 0);
    push_request(KIND_ALLOC, 5, 0);
    push_request(KIND_FREE_REC, 0, 0);        // opens a hole of three
    push_request(KIND_ALLOC, 4, 0);           // skips the hole
    push_request(KIND_ALLOC, 2, 0);           // fits in the hole
    push_request(KIND_ALLOC, 1, 0);
    push_request(KIND_FREE_CNT, 1, 512);      // frame at the start of a word
    push_request(KIND_FREE_REC, 2047, 3);     // length recorded by the second run
    push_request(KIND_RSVD, 0, 0);
    push_request(KIND_ALLOC, 31, 0);
    push_request(KIND_FREE_CNT, FRAMES, 0);
    drain();

    // Random part in three phases of idling: sender busy, then receiver busy,
    // then both at full rate. Each phase ends with a full drain.
    done_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 38; recv_idle = 53; end
        1: begin send_idle = 53; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      while (done_items < (RAND_ITEMS * (phase + 1)) / 3) begin
        random_item(counted);
        if (counted) done_items++;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests: %0d allocate, %0d free by record, %0d free by count,",
             n_alloc + n_frec + n_fcnt + n_rsvd, n_alloc, n_frec, n_fcnt);
    $display("%0d reserved; %0d responses compared, %0d allocations granted.",
             n_rsvd, checked, granted);
    if (errors == 0 && due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfa_pkg.sv
rtl/cfa_req_if.sv
rtl/cfa_rsp_if.sv
rtl/cfa_run_scan.sv
rtl/contiguous_frame_allocator.sv
test/frame_alloc_checker.sv
test/tb.sv
